[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL. The properties are dropped for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

[rtl/c2d_pkg.sv]
`timescale 1ns / 1ps
package c2d_pkg;

  localparam int MAX_IN_CHANNELS  = 64;
  localparam int MAX_OUT_CHANNELS = 64;
  localparam int MAX_KERNEL       = 9;
  localparam int MAX_DIM          = 32;
  localparam int WEIGHT_DEPTH     = 65536;
  localparam int ACT_DEPTH        = 65536;
  localparam int FRAC_BITS        = 12;

  localparam int W_ADDR_W = $clog2(WEIGHT_DEPTH);
  localparam int A_ADDR_W = $clog2(ACT_DEPTH);
  localparam int B_ADDR_W = $clog2(MAX_OUT_CHANNELS);

  localparam logic [1:0] ACT_WEIGHT  = 2'd0;
  localparam logic [1:0] ACT_BIAS    = 2'd1;
  localparam logic [1:0] ACT_ACTIV   = 2'd2;
  localparam logic [1:0] ACT_COMPUTE = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  localparam logic [2:0] REG_IN_CH  = 3'd0;
  localparam logic [2:0] REG_OUT_CH = 3'd1;
  localparam logic [2:0] REG_KERNEL = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [2:0] REG_RELU   = 3'd5;

  typedef struct packed {
    logic [4:0]  out_y;
    logic [4:0]  out_x;
    logic [5:0]  out_channel;
    logic [15:0] value;
    logic [15:0] address;
  } in_word_t;

endpackage

[rtl/c2d_ram.sv]
`timescale 1ns / 1ps
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/conv2d_layer_relu.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One valid-mode convolution layer with bias and optional ReLU in Q4.12.
// The input channel carries words whose tuser is the action: weight, bias and
// activation loads write one memory word and return nothing (a bias load only
// writes when its address is below 64); a compute word returns one result word
// with the value in out_tdata and the status in out_tuser (ok, saturated, or
// out of range). A load leaves the block idle and ready for another word.
// A compute runs four set-up states for the address products and the bias read,
// one multiply-accumulate per cycle fed by the weight and activation memories,
// a drain of the read, multiply and accumulate stages, and a done state that
// forms the result; one that fails the range checks skips the run and drain.
// The input is not ready again until the block is back in idle, so no new word
// is taken while a compute is in progress.
// Results sit in an output register; loads are still taken while it waits,
// and a compute that finishes while the receiver stalls holds until it is free.
// Configuration is written on the cfg channel, which is always ready; the user
// must write it only while the block is idle, which the block does not enforce.
// Synchronous reset restores the default registers and empties the pipeline;
// the memory contents are undefined until loaded.
module conv2d_layer_relu
  import c2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // address, value, out_channel, out_x, out_y
  input  logic [1:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // result_value
  output logic [1:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP1 = 3'd1;
  localparam logic [2:0] S_PREP2 = 3'd2;
  localparam logic [2:0] S_PREP3 = 3'd3;
  localparam logic [2:0] S_PREP4 = 3'd4;
  localparam logic [2:0] S_RUN   = 3'd5;
  localparam logic [2:0] S_DRAIN = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  in_word_t in_w;
  logic     in_acc;

  logic [6:0] ic_r, ocn_r;
  logic [3:0] k_r;
  logic [5:0] w_r, h_r;
  logic       relu_r;

  logic [2:0] state_r, state_nxt;
  logic [5:0] oc_r;
  logic [4:0] ox_r, oy_r;
  logic       err_r;

  logic [7:0]  kk_r;
  logic [11:0] plane_r;
  logic [10:0] row_off_r;
  logic [14:0] ick_r;
  logic [18:0] icp_r;
  logic [21:0] wend_r;
  logic        store_bad;

  logic [A_ADDR_W-1:0] a_ch_r, a_row_r, a_addr_r;
  logic [W_ADDR_W-1:0] w_addr_r;
  logic [3:0]          kx_r, ky_r;
  logic [5:0]          c_r;
  logic                last_kx, last_ky, last_c;

  logic               rd_v_r, mul_v_r;
  logic signed [15:0] act_rd, wt_rd, bias_rd;
  logic signed [31:0] prod_r;
  logic signed [47:0] acc_r;

  logic        cfg_bad, pos_bad;
  logic [6:0]  x_end, y_end;

  logic signed [35:0] shifted;
  logic [15:0]        res_val;
  logic [1:0]         res_st;
  logic               out_free;

  logic        out_tvalid_r;
  logic [15:0] out_tdata_r;
  logic [1:0]  out_tuser_r;

  assign in_w      = in_tdata;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ic_r   <= 7'd1;
      ocn_r  <= 7'd64;
      k_r    <= 4'd9;
      w_r    <= 6'd32;
      h_r    <= 6'd32;
      relu_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IN_CH:  ic_r   <= cfg_data;
        REG_OUT_CH: ocn_r  <= cfg_data;
        REG_KERNEL: k_r    <= cfg_data[3:0];
        REG_WIDTH:  w_r    <= cfg_data[5:0];
        REG_HEIGHT: h_r    <= cfg_data[5:0];
        REG_RELU:   relu_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Memories.
  c2d_ram #(.WIDTH(16), .DEPTH(WEIGHT_DEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (in_acc && (in_tuser == ACT_WEIGHT)),
    .addr  ((state_r == S_RUN) ? w_addr_r : in_w.address[W_ADDR_W-1:0]),
    .wdata (in_w.value),
    .rdata (wt_rd)
  );

  c2d_ram #(.WIDTH(16), .DEPTH(ACT_DEPTH)) u_act_ram (
    .clk   (clk),
    .we    (in_acc && (in_tuser == ACT_ACTIV)),
    .addr  ((state_r == S_RUN) ? a_addr_r : in_w.address[A_ADDR_W-1:0]),
    .wdata (in_w.value),
    .rdata (act_rd)
  );

  c2d_ram #(.WIDTH(16), .DEPTH(MAX_OUT_CHANNELS)) u_bias_ram (
    .clk   (clk),
    .we    (in_acc && (in_tuser == ACT_BIAS) &&
            (32'(in_w.address) < MAX_OUT_CHANNELS)),
    .addr  ((state_r == S_IDLE) ? in_w.address[B_ADDR_W-1:0] : oc_r[B_ADDR_W-1:0]),
    .wdata (in_w.value),
    .rdata (bias_rd)
  );

  // Range checks.
  assign x_end = 7'(ox_r) + 7'(k_r);
  assign y_end = 7'(oy_r) + 7'(k_r);
  assign cfg_bad = (ic_r == 7'd0) || (32'(ic_r) > MAX_IN_CHANNELS) ||
                   (ocn_r == 7'd0) || (32'(ocn_r) > MAX_OUT_CHANNELS) ||
                   (k_r == 4'd0) || (32'(k_r) > MAX_KERNEL) ||
                   (w_r == 6'd0) || (32'(w_r) > MAX_DIM) ||
                   (h_r == 6'd0) || (32'(h_r) > MAX_DIM);
  assign pos_bad = (7'(oc_r) >= ocn_r) || (x_end > 7'(w_r)) || (y_end > 7'(h_r));
  assign store_bad = (wend_r > 22'(WEIGHT_DEPTH)) || (icp_r > 19'(ACT_DEPTH));

  assign last_kx = (kx_r == k_r - 4'd1);
  assign last_ky = (ky_r == k_r - 4'd1);
  assign last_c  = (7'(c_r) == ic_r - 7'd1);

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc && (in_tuser == ACT_COMPUTE)) state_nxt = S_PREP1;
      S_PREP1: state_nxt = S_PREP2;
      S_PREP2: state_nxt = S_PREP3;
      S_PREP3: state_nxt = S_PREP4;
      S_PREP4: begin
        if (err_r || store_bad) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RUN;
        end
      end
      S_RUN:   if (last_kx && last_ky && last_c) state_nxt = S_DRAIN;
      S_DRAIN: if (!rd_v_r && !mul_v_r) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_v_r  <= 1'b0;
      mul_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == S_RUN);
      mul_v_r <= rd_v_r;
    end
  end

  // Set-up products and the address walk.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        oc_r <= in_w.out_channel;
        ox_r <= in_w.out_x;
        oy_r <= in_w.out_y;
      end
      S_PREP1: begin
        kk_r      <= 8'(k_r * k_r);
        plane_r   <= 12'(w_r * h_r);
        row_off_r <= 11'(oy_r * w_r);
        err_r     <= cfg_bad || pos_bad;
      end
      S_PREP2: begin
        ick_r <= 15'(ic_r * kk_r);
        icp_r <= 19'(ic_r * plane_r);
        a_ch_r   <= A_ADDR_W'(row_off_r) + A_ADDR_W'(ox_r);
        a_row_r  <= A_ADDR_W'(row_off_r) + A_ADDR_W'(ox_r);
        a_addr_r <= A_ADDR_W'(row_off_r) + A_ADDR_W'(ox_r);
        acc_r    <= {{20{bias_rd[15]}}, bias_rd, {FRAC_BITS{1'b0}}};
      end
      S_PREP3: begin
        wend_r <= 22'((7'(oc_r) + 7'd1) * ick_r);
      end
      S_PREP4: begin
        err_r    <= err_r || store_bad;
        w_addr_r <= W_ADDR_W'(wend_r - 22'(ick_r));
        kx_r     <= 4'd0;
        ky_r     <= 4'd0;
        c_r      <= 6'd0;
      end
      S_RUN: begin
        w_addr_r <= w_addr_r + W_ADDR_W'(1);
        if (last_kx) begin
          kx_r <= 4'd0;
          if (last_ky) begin
            ky_r     <= 4'd0;
            c_r      <= c_r + 6'd1;
            a_ch_r   <= a_ch_r + A_ADDR_W'(plane_r);
            a_row_r  <= a_ch_r + A_ADDR_W'(plane_r);
            a_addr_r <= a_ch_r + A_ADDR_W'(plane_r);
          end else begin
            ky_r     <= ky_r + 4'd1;
            a_row_r  <= a_row_r + A_ADDR_W'(w_r);
            a_addr_r <= a_row_r + A_ADDR_W'(w_r);
          end
        end else begin
          kx_r     <= kx_r + 4'd1;
          a_addr_r <= a_addr_r + A_ADDR_W'(1);
        end
      end
      default: ;
    endcase
    if (rd_v_r) begin
      prod_r <= act_rd * wt_rd;
    end
    if (mul_v_r) begin
      acc_r <= acc_r + {{16{prod_r[31]}}, prod_r};
    end
  end

  // Floor shift, ReLU and saturation.
  assign shifted = acc_r[47:FRAC_BITS];
  always_comb begin
    res_st  = ST_OK;
    res_val = shifted[15:0];
    if (err_r) begin
      res_st  = ST_ERR;
      res_val = 16'd0;
    end else if (relu_r && shifted[35]) begin
      res_val = 16'd0;
    end else if (!shifted[35] && (|shifted[34:15])) begin
      res_st  = ST_SAT;
      res_val = 16'h7fff;
    end else if (shifted[35] && !(&shifted[34:15])) begin
      res_st  = ST_SAT;
      res_val = 16'h8000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if ((state_r == S_DONE) && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && out_free) begin
      out_tdata_r <= res_val;
      out_tuser_r <= res_st;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  `ASSERT_CLKD(a_idle_pipe_empty, clk, rst_n, in_tready |-> (!rd_v_r && !mul_v_r),
               "input taken while the MAC pipeline is busy")
  `ASSERT_CLKD(a_read_from_run, clk, rst_n, rd_v_r |-> $past(state_r == S_RUN),
               "memory read valid outside the run phase")
  `ASSERT_CLKD(a_err_zero, clk, rst_n,
               (out_tvalid && (out_tuser == ST_ERR)) |-> (out_tdata == 16'd0),
               "error result with a nonzero value")
  `ASSERT_NEVER(a_status_code, clk, rst_n,
                out_tvalid && (out_tuser != ST_OK) && (out_tuser != ST_SAT) &&
                (out_tuser != ST_ERR), "undefined status code")

endmodule
